>>> design/assert_macros.svh
// assert_macros.svh: concurrent assertion macros used by the delay block rtl
// no dependencies; bodies collapse to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SFD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/sfd_pkg.sv
// sfd_pkg: types and fixed constants of the stereo feedback delay block
// used by sfd_mul, sfd_ring, sfd_seq and the top level
`default_nettype none

package sfd_pkg;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int CTRL_W   = 17;
   localparam int CSR_W    = 2;
   localparam int REQ_W    = 88;
   localparam int RSP_W    = 48;

   // shared multiplier: signed operands, registered product
   localparam int MUL_W  = 28;
   localparam int PROD_W = 2 * MUL_W;

   // feedback arithmetic
   localparam int FB9_W  = 20;
   localparam int MAG_W  = 43;
   localparam int QUOT_W = 27;
   localparam logic [CTRL_W-1:0] FB_ONE      = 17'd65536;
   localparam logic [MAG_W-1:0]  FB_ROUND    = 43'd327680;
   localparam logic [QUOT_W-1:0] RECIP_TEN   = 27'd107374183;
   localparam int                RECIP_SHIFT = 30;

   // delay scaling
   localparam int DSUM_W = 35;
   localparam int DR_W   = 19;
   localparam logic [DSUM_W-1:0] DELAY_ROUND = 35'd32768;

   // sample saturation limits
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   // csr reset value: stereo
   localparam logic [CSR_W-1:0] CHANNELS_RESET = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DELAY,
      S_ADDR,
      S_READ,
      S_FBMUL,
      S_RECIP,
      S_WRITE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

>>> design/stereo_feedback_delay_top.sv
// stereo_feedback_delay_top: stereo feedback comb filter, top level
// depends on sfd_pkg, sfd_mul, sfd_ring and sfd_seq
//
// Usage:
//   req_* carries one stereo sample pair with its delay time and feedback
//   controls; rsp_* returns one delayed pair per request, in order.
//   csr_wr_en / csr_wr_data write the channel count (one = mono, two = stereo);
//   write it only while no request is in flight.
//   Sequence: after acceptance a request passes DELAY, ADDR and READ, then
//   FBMUL, RECIP and WRITE per channel, then OUT, which loads the result
//   into the output register; only then is the next request taken. One
//   shared multiplier is used once for delay scaling and twice per channel
//   (feedback product, divide by ten by reciprocal) and the rings are read
//   once per request. req_tready is high only while the sequencer is idle.
//   Reset: synchronous; afterwards all MAX_DELAY + 1 ring entries (4096 at
//   the default) are swept to zero, one entry per cycle, with req_tready low.
//   Stall: the result sits in the output register while rsp_tready is low;
//   the next request is still taken and worked on, and waits at its end until
//   the output register frees up.
`default_nettype none

module stereo_feedback_delay_top #(
   parameter int MAX_DELAY = 4095
) (
   input  wire         clock,
   input  wire         reset,
   // request: [23:0] left_sample, [47:24] right_sample,
   //          [64:48] time_fraction, [81:65] feedback_amount, [87:82] zero
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [87:0] req_tdata,
   // response: [23:0] left_out, [47:24] right_out
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,
   // channel count register
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_wr_data
);
   import sfd_pkg::*;

   localparam int RING_LEN = MAX_DELAY + 1;
   localparam int AW       = $clog2(RING_LEN);

   mul_req_type                mul_req;
   logic signed [PROD_W-1:0]   mul_prod;
   logic                       ring_wr_left;
   logic                       ring_wr_right;
   logic [AW-1:0]              ring_wr_addr;
   logic signed [SAMPLE_W-1:0] ring_wr_data;
   logic                       ring_rd_en;
   logic [AW-1:0]              ring_rd_addr;
   logic signed [SAMPLE_W-1:0] left_rd_data;
   logic signed [SAMPLE_W-1:0] right_rd_data;

   // sequencer and datapath
   sfd_seq #(
      .MAX_DELAY (MAX_DELAY)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mul_req       (mul_req),
      .mul_prod      (mul_prod),
      .ring_wr_left  (ring_wr_left),
      .ring_wr_right (ring_wr_right),
      .ring_wr_addr  (ring_wr_addr),
      .ring_wr_data  (ring_wr_data),
      .ring_rd_en    (ring_rd_en),
      .ring_rd_addr  (ring_rd_addr),
      .left_rd_data  (left_rd_data),
      .right_rd_data (right_rd_data)
   );

   // shared multiplier
   sfd_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (mul_prod)
   );

   // left ring
   sfd_ring #(
      .DEPTH (RING_LEN)
   ) u_ring_left (
      .clock      (clock),
      .wr_en      (ring_wr_left),
      .wr_addr    (ring_wr_addr),
      .wr_data    (ring_wr_data),
      .rd_en      (ring_rd_en),
      .rd_addr    (ring_rd_addr),
      .rd_data_ff (left_rd_data)
   );

   // right ring
   sfd_ring #(
      .DEPTH (RING_LEN)
   ) u_ring_right (
      .clock      (clock),
      .wr_en      (ring_wr_right),
      .wr_addr    (ring_wr_addr),
      .wr_data    (ring_wr_data),
      .rd_en      (ring_rd_en),
      .rd_addr    (ring_rd_addr),
      .rd_data_ff (right_rd_data)
   );

endmodule

`default_nettype wire

>>> design/sfd_mul.sv
// sfd_mul: shared signed multiplier with registered product
// depends on sfd_pkg
`default_nettype none

module sfd_mul (
   input  wire                                    clock,
   input  sfd_pkg::mul_req_type                   mul_req,
   output logic signed [sfd_pkg::PROD_W-1:0]      prod_ff
);
   import sfd_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   // full-width signed product
   always_comb begin
      prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> design/sfd_ring.sv
// sfd_ring: one delay ring, single write port and registered read port
// depends on sfd_pkg
`default_nettype none

module sfd_ring #(
   parameter int DEPTH = 4096
) (
   input  wire                                     clock,
   input  wire                                     wr_en,
   input  wire  [$clog2(DEPTH)-1:0]                wr_addr,
   input  wire  signed [sfd_pkg::SAMPLE_W-1:0]     wr_data,
   input  wire                                     rd_en,
   input  wire  [$clog2(DEPTH)-1:0]                rd_addr,
   output logic signed [sfd_pkg::SAMPLE_W-1:0]     rd_data_ff
);
   import sfd_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [0:DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/sfd_seq.sv
// sfd_seq: sequencer and datapath of the stereo feedback delay
// depends on sfd_pkg and assert_macros.svh; drives sfd_mul and two sfd_ring
`default_nettype none
`include "assert_macros.svh"

module sfd_seq #(
   parameter int MAX_DELAY = 4095
) (
   input  wire                                        clock,
   input  wire                                        reset,
   // request channel
   input  wire                                        req_tvalid,
   output logic                                       req_tready,
   input  wire  [sfd_pkg::REQ_W-1:0]                  req_tdata,
   // response channel
   output logic                                       rsp_tvalid,
   input  wire                                        rsp_tready,
   output logic [sfd_pkg::RSP_W-1:0]                  rsp_tdata,
   // channel count register
   input  wire                                        csr_wr_en,
   input  wire  [sfd_pkg::CSR_W-1:0]                  csr_wr_data,
   // shared multiplier
   output sfd_pkg::mul_req_type                       mul_req,
   input  wire  signed [sfd_pkg::PROD_W-1:0]          mul_prod,
   // rings
   output logic                                       ring_wr_left,
   output logic                                       ring_wr_right,
   output logic [$clog2(MAX_DELAY+1)-1:0]             ring_wr_addr,
   output logic signed [sfd_pkg::SAMPLE_W-1:0]        ring_wr_data,
   output logic                                       ring_rd_en,
   output logic [$clog2(MAX_DELAY+1)-1:0]             ring_rd_addr,
   input  wire  signed [sfd_pkg::SAMPLE_W-1:0]        left_rd_data,
   input  wire  signed [sfd_pkg::SAMPLE_W-1:0]        right_rd_data
);
   import sfd_pkg::*;

   localparam int RING_LEN = MAX_DELAY + 1;
   localparam int AW       = $clog2(RING_LEN);

   state_type                  state_ff, state_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [AW-1:0]              rp_ff, rp_in;
   logic                       ch_ff, ch_in;
   logic                       neg_ff, neg_in;
   logic [CSR_W-1:0]           csr_ff;
   logic signed [SAMPLE_W-1:0] xl_ff, xl_in;
   logic signed [SAMPLE_W-1:0] xr_ff, xr_in;
   logic [CTRL_W-1:0]          t_ff, t_in;
   logic [FB9_W-1:0]           fb9_ff, fb9_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;

   logic                       stereo;
   logic [AW-1:0]              wp_next;
   logic [CTRL_W-1:0]          fb_raw;
   logic [CTRL_W-1:0]          fb_clamped;
   logic [DSUM_W-1:0]          delay_sum;
   logic [DR_W-1:0]            delay_raw;
   logic [AW-1:0]              delay;
   logic [AW:0]                rp_diff;
   logic [AW:0]                rp_wrap;
   logic signed [SAMPLE_W-1:0] sel_delayed;
   logic signed [SAMPLE_W-1:0] sel_x;
   logic [MAG_W-1:0]           prod_mag;
   logic [MAG_W-1:0]           mag_rounded;
   logic [QUOT_W-1:0]          mag_scaled;
   logic [SAMPLE_W-1:0]        quot;
   logic signed [SAMPLE_W:0]   term;
   logic signed [SAMPLE_W:0]   comb_sum;
   logic signed [SAMPLE_W-1:0] comb_sat;

   assign stereo = csr_ff[1];

   // write position increment with wrap
   assign wp_next = (wp_ff == AW'(MAX_DELAY)) ? '0 : wp_ff + AW'(1);

   // feedback clamp to one
   assign fb_raw     = req_tdata[81:65];
   assign fb_clamped = (fb_raw > FB_ONE) ? FB_ONE : fb_raw;

   // delay = round(t * max_delay), clamped to 1..max_delay
   always_comb begin
      delay_sum = mul_prod[DSUM_W-1:0] + DELAY_ROUND;
      delay_raw = delay_sum[DSUM_W-1:16];
      if (delay_raw == '0) begin
         delay = AW'(1);
      end else if (delay_raw > DR_W'(MAX_DELAY)) begin
         delay = AW'(MAX_DELAY);
      end else begin
         delay = delay_raw[AW-1:0];
      end
      rp_diff = {1'b0, wp_ff} - {1'b0, delay};
      rp_wrap = rp_diff[AW] ? rp_diff + (AW+1)'(RING_LEN) : rp_diff;
   end

   // channel select for the feedback path
   assign sel_delayed = ch_ff ? right_rd_data : left_rd_data;
   assign sel_x       = ch_ff ? xr_ff : xl_ff;

   // |delayed * fb * 9| rounded and pre-shifted; the /10 is done by reciprocal
   always_comb begin
      prod_mag    = mul_prod[PROD_W-1] ? MAG_W'(-mul_prod) : MAG_W'(mul_prod);
      mag_rounded = prod_mag + FB_ROUND;
      mag_scaled  = mag_rounded[MAG_W-1:16];
   end

   // signed sum with 24-bit saturation
   always_comb begin
      quot     = mul_prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
      term     = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      comb_sum = {sel_x[SAMPLE_W-1], sel_x} + term;
      if (comb_sum[SAMPLE_W] != comb_sum[SAMPLE_W-1]) begin
         comb_sat = comb_sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         comb_sat = comb_sum[SAMPLE_W-1:0];
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wp_ff        <= '0;
         ch_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // channel count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CHANNELS_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rp_ff        <= rp_in;
      neg_ff       <= neg_in;
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      t_ff         <= t_in;
      fb9_ff       <= fb9_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      ch_in         = ch_ff;
      neg_in        = neg_ff;
      xl_in         = xl_ff;
      xr_in         = xr_ff;
      t_in          = t_ff;
      fb9_in        = fb9_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      req_tready    = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      ring_wr_left  = 1'b0;
      ring_wr_right = 1'b0;
      ring_wr_addr  = wp_ff;
      ring_wr_data  = comb_sat;
      ring_rd_en    = 1'b0;

      case (state_ff)
         // zero both rings, one entry per cycle
         S_CLEAR: begin
            ring_wr_left  = 1'b1;
            ring_wr_right = 1'b1;
            ring_wr_data  = '0;
            wp_in         = wp_next;
            if (wp_ff == AW'(MAX_DELAY)) begin
               state_in = S_IDLE;
            end
         end
         // take a request
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               xl_in    = req_tdata[23:0];
               xr_in    = req_tdata[47:24];
               t_in     = req_tdata[64:48];
               fb9_in   = FB9_W'({fb_clamped, 3'b000}) + FB9_W'(fb_clamped);
               state_in = S_DELAY;
            end
         end
         // t * max_delay
         S_DELAY: begin
            mul_req.a = $signed(MUL_W'(t_ff));
            mul_req.b = $signed(MUL_W'(MAX_DELAY));
            state_in  = S_ADDR;
         end
         // read position behind the write position
         S_ADDR: begin
            rp_in    = rp_wrap[AW-1:0];
            state_in = S_READ;
         end
         // fetch both rings
         S_READ: begin
            ring_rd_en = 1'b1;
            ch_in      = 1'b0;
            state_in   = S_FBMUL;
         end
         // delayed * fb * 9
         S_FBMUL: begin
            mul_req.a = MUL_W'(sel_delayed);
            mul_req.b = $signed(MUL_W'(fb9_ff));
            state_in  = S_RECIP;
         end
         // rounded magnitude times the reciprocal of ten
         S_RECIP: begin
            neg_in    = mul_prod[PROD_W-1];
            mul_req.a = $signed(MUL_W'(mag_scaled));
            mul_req.b = $signed(MUL_W'(RECIP_TEN));
            state_in  = S_WRITE;
         end
         // store input plus feedback
         S_WRITE: begin
            ring_wr_left  = !ch_ff;
            ring_wr_right = ch_ff;
            if (!ch_ff && stereo) begin
               ch_in    = 1'b1;
               state_in = S_FBMUL;
            end else begin
               state_in = S_OUT;
            end
         end
         // load the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_rd_data;
               rsp_right_in = stereo ? right_rd_data : xr_ff;
               wp_in        = wp_next;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ring_rd_addr = rp_ff;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_right_ff, rsp_left_ff};

   // assertions
   `SFD_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_OUT))
   `SFD_ASSERT_NEXT(a_req_starts, clock, reset, req_tvalid && req_tready, state_ff == S_DELAY)
   `SFD_ASSERT_IMPLY(a_wr_not_rd, clock, reset, (ring_wr_left || ring_wr_right) && state_ff != S_CLEAR, ring_wr_addr != rp_ff)
   `SFD_ASSERT_IMPLY(a_one_ring, clock, reset, state_ff != S_CLEAR, $onehot0({ring_wr_left, ring_wr_right}))
   `SFD_ASSERT_IMPLY(a_mono_right, clock, reset, state_ff != S_CLEAR && !stereo, !ring_wr_right)

endmodule

`default_nettype wire
